// ----- src/gnmk_pkg.sv -----
package gnmk_pkg;

    // configuration register indexes
    localparam logic CFG_KEEP_FRACTION = 1'b0;
    localparam logic CFG_PER_ATOM      = 1'b1;

    // result verdicts
    localparam logic [1:0] VERDICT_PASS     = 2'd0;
    localparam logic [1:0] VERDICT_DROP     = 2'd1;
    localparam logic [1:0] VERDICT_RELEASE  = 2'd2;
    localparam logic [1:0] VERDICT_TABLE_FULL = 2'd3;

    // input function codes
    localparam logic FUNC_OFFER   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic        func;
        logic [31:0] item_id;
        logic [15:0] group_key;
        logic        has_value;
        logic [31:0] value;
    } cmd_t;

    // one stored list entry
    typedef struct packed {
        logic [31:0] value;
        logic [31:0] id;
    } entry_t;

endpackage

// ----- src/gnmk_front.sv -----
module gnmk_front
    import gnmk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        per_atom,
    input  logic        in_valid,
    output logic        in_ready,
    input  cmd_t        in_cmd,
    input  logic [7:0]  atom_count,
    output logic        push_valid,
    input  logic        push_ready,
    output cmd_t        push_cmd
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

    fstate_t     st_reg;
    cmd_t        cmd_reg;
    logic [31:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  div_reg;
    logic        neg_reg;
    logic [4:0]  step_reg;

    logic [8:0]  rem_shift;
    logic        rem_ge;
    logic [8:0]  rem_next;
    logic [31:0] quo_next;
    logic [31:0] mag;

    assign in_ready   = (st_reg == F_IDLE);
    assign push_valid = (st_reg == F_PUSH);
    assign push_cmd   = cmd_reg;

    // restoring divide, one quotient bit per cycle
    assign rem_shift = {rem_reg[7:0], quo_reg[31]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rem_next  = rem_ge ? (rem_shift - {1'b0, div_reg}) : rem_shift;
    assign quo_next  = {quo_reg[30:0], rem_ge};
    assign mag       = in_cmd.value[31] ? (32'd0 - in_cmd.value) : in_cmd.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
        end
        else
        begin
            unique case (st_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= in_cmd;
                        if (in_cmd.func == FUNC_OFFER && in_cmd.has_value && per_atom
                            && atom_count > 8'd1)
                        begin
                            quo_reg  <= mag;
                            rem_reg  <= '0;
                            div_reg  <= atom_count;
                            neg_reg  <= in_cmd.value[31];
                            step_reg <= '0;
                            st_reg   <= F_DIV;
                        end
                        else
                        begin
                            st_reg <= F_PUSH;
                        end
                    end
                end
                F_DIV:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        cmd_reg.value <= neg_reg ? (32'd0 - quo_next) : quo_next;
                        st_reg        <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (push_ready)
                        st_reg <= F_IDLE;
                end
                default: st_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- src/gnmk_fifo.sv -----
module gnmk_fifo
    import gnmk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t       slot_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_reg <= ~wr_reg;
            if (do_pop)
                rd_reg <= ~rd_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ----- src/gnmk_back.sv -----
module gnmk_back
    import gnmk_pkg::*;
#(
    parameter int GROUPS  = 4,
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] keep_fraction,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  cmd_t        pop_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_id,
    output logic [1:0]  out_verdict,
    output logic        out_last
);

    localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GIW = $clog2(GROUPS + 1);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int AW  = $clog2(GROUPS * ENTRIES);
    localparam int MD  = GROUPS * ENTRIES;

    typedef enum logic [3:0] {
        S_IDLE, S_PASS, S_LOOK, S_HEAD, S_DECIDE, S_TAIL, S_WALK, S_WCHK,
        S_PMUL, S_PRD, S_PCHK, S_REL, S_RCHK, S_FINISH
    } bstate_t;

    function automatic logic [AW-1:0] addr_of(input logic [GW-1:0] g, input logic [CW-1:0] i);
        return AW'(int'(g) * ENTRIES + int'(i));
    endfunction

    bstate_t        st_reg;
    cmd_t           cmd_reg;
    logic [GW-1:0]  g_reg;
    logic [CW-1:0]  c_reg;
    logic [CW-1:0]  i_reg;
    logic [GIW-1:0] rg_reg;
    logic           newlow_reg;
    logic signed [49:0] prod_reg;

    logic           used_reg [GROUPS];
    logic [15:0]    key_reg  [GROUPS];
    logic [CW-1:0]  cnt_reg  [GROUPS];

    entry_t         mem [MD];
    entry_t         rd_q;

    logic           pend_valid_reg;
    logic [31:0]    pend_id_reg;
    logic [1:0]     pend_verdict_reg;
    logic           out_valid_reg;
    logic [31:0]    out_id_reg;
    logic [1:0]     out_verdict_reg;
    logic           out_last_reg;

    // lookup
    logic           hit;
    logic [GW-1:0]  hit_idx;
    logic           free;
    logic [GW-1:0]  free_idx;

    // memory port control
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    entry_t         wr_data;

    // result generation
    logic           emit_req;
    logic [31:0]    emit_id;
    logic [1:0]     emit_verdict;
    logic           out_free;
    logic           can_push;
    logic           emit_go;

    logic signed [31:0] v;
    logic signed [31:0] rd_val;
    logic signed [49:0] lhs;
    logic signed [49:0] rd_lhs;
    logic signed [31:0] mul_a;
    logic [16:0]        mul_m;
    logic signed [49:0] mul_p;
    logic [GW-1:0]      rg_idx;

    assign v      = $signed(cmd_reg.value);
    assign rd_val = $signed(rd_q.value);
    assign lhs    = {{2{v[31]}}, v, 16'd0};
    assign rd_lhs = {{2{rd_val[31]}}, rd_val, 16'd0};
    assign mul_m  = 17'h10000 - {1'b0, keep_fraction};
    assign mul_a  = (st_reg == S_HEAD) ? rd_val : v;
    assign mul_p  = mul_a * $signed({1'b0, mul_m});
    assign rg_idx = rg_reg[GW-1:0];

    assign out_free  = !out_valid_reg || out_ready;
    assign can_push  = !pend_valid_reg || out_free;
    assign emit_go   = emit_req && can_push;
    assign pop_ready = (st_reg == S_IDLE);

    assign out_valid   = out_valid_reg;
    assign out_id      = out_id_reg;
    assign out_verdict = out_verdict_reg;
    assign out_last    = out_last_reg;

    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (used_reg[g] && key_reg[g] == cmd_reg.group_key)
            begin
                hit     = 1'b1;
                hit_idx = GW'(g);
            end
            if (!used_reg[g])
            begin
                free     = 1'b1;
                free_idx = GW'(g);
            end
        end
    end

    always_comb
    begin
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '{value: cmd_reg.value, id: cmd_reg.item_id};
        emit_req     = 1'b0;
        emit_id      = cmd_reg.item_id;
        emit_verdict = VERDICT_DROP;
        case (st_reg)
            S_PASS:
            begin
                emit_req     = 1'b1;
                emit_verdict = VERDICT_PASS;
            end
            S_LOOK:
            begin
                if (hit)
                begin
                    if (cnt_reg[hit_idx] == '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(hit_idx, '0);
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = addr_of(hit_idx, '0);
                    end
                end
                else if (free)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_of(free_idx, '0);
                end
                else
                begin
                    emit_req     = 1'b1;
                    emit_verdict = VERDICT_TABLE_FULL;
                end
            end
            S_DECIDE:
            begin
                if (newlow_reg || lhs < prod_reg)
                begin
                    if (c_reg == CW'(ENTRIES))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = addr_of(g_reg, c_reg - CW'(1));
                    end
                end
                else
                begin
                    emit_req = 1'b1;
                end
            end
            S_TAIL:
            begin
                emit_req = 1'b1;
                if (newlow_reg || v < rd_val)
                    emit_id = rd_q.id;
            end
            S_WALK:
            begin
                if (i_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_of(g_reg, '0);
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = addr_of(g_reg, i_reg - CW'(1));
                end
            end
            S_WCHK:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_of(g_reg, i_reg);
                if (rd_val > v)
                    wr_data = rd_q;
            end
            S_PRD:
            begin
                if (cnt_reg[g_reg] != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = addr_of(g_reg, cnt_reg[g_reg] - CW'(1));
                end
            end
            S_PCHK:
            begin
                if (rd_lhs > prod_reg)
                begin
                    emit_req = 1'b1;
                    emit_id  = rd_q.id;
                end
            end
            S_REL:
            begin
                if (rg_reg != GIW'(GROUPS) && used_reg[rg_idx] && i_reg != cnt_reg[rg_idx])
                begin
                    rd_en   = 1'b1;
                    rd_addr = addr_of(rg_idx, i_reg);
                end
            end
            S_RCHK:
            begin
                emit_req     = 1'b1;
                emit_id      = rd_q.id;
                emit_verdict = VERDICT_RELEASE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int g = 0; g < GROUPS; g++)
            begin
                used_reg[g] <= 1'b0;
                cnt_reg[g]  <= '0;
            end
        end
        else
        begin
            // result path: pending result, then output register
            if (emit_go)
            begin
                pend_valid_reg   <= 1'b1;
                pend_id_reg      <= emit_id;
                pend_verdict_reg <= emit_verdict;
                if (pend_valid_reg)
                begin
                    out_valid_reg   <= 1'b1;
                    out_id_reg      <= pend_id_reg;
                    out_verdict_reg <= pend_verdict_reg;
                    out_last_reg    <= 1'b0;
                end
                else if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (st_reg == S_FINISH && pend_valid_reg && out_free)
            begin
                pend_valid_reg  <= 1'b0;
                out_valid_reg   <= 1'b1;
                out_id_reg      <= pend_id_reg;
                out_verdict_reg <= pend_verdict_reg;
                out_last_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (st_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        cmd_reg <= pop_data;
                        rg_reg  <= '0;
                        i_reg   <= '0;
                        if (pop_data.func == FUNC_RELEASE)
                            st_reg <= S_REL;
                        else if (!pop_data.has_value)
                            st_reg <= S_PASS;
                        else
                            st_reg <= S_LOOK;
                    end
                end
                S_PASS:
                begin
                    if (emit_go)
                        st_reg <= S_FINISH;
                end
                S_LOOK:
                begin
                    if (hit)
                    begin
                        g_reg <= hit_idx;
                        c_reg <= cnt_reg[hit_idx];
                        if (cnt_reg[hit_idx] == '0)
                        begin
                            cnt_reg[hit_idx] <= CW'(1);
                            st_reg           <= S_FINISH;
                        end
                        else
                        begin
                            st_reg <= S_HEAD;
                        end
                    end
                    else if (free)
                    begin
                        used_reg[free_idx] <= 1'b1;
                        key_reg[free_idx]  <= cmd_reg.group_key;
                        cnt_reg[free_idx]  <= CW'(1);
                        st_reg             <= S_FINISH;
                    end
                    else if (emit_go)
                    begin
                        st_reg <= S_FINISH;
                    end
                end
                S_HEAD:
                begin
                    prod_reg   <= mul_p;
                    newlow_reg <= (v < rd_val);
                    st_reg     <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (newlow_reg || lhs < prod_reg)
                    begin
                        i_reg  <= c_reg;
                        st_reg <= (c_reg == CW'(ENTRIES)) ? S_TAIL : S_WALK;
                    end
                    else if (emit_go)
                    begin
                        st_reg <= S_FINISH;
                    end
                end
                S_TAIL:
                begin
                    if (emit_go)
                    begin
                        if (newlow_reg || v < rd_val)
                        begin
                            c_reg  <= c_reg - CW'(1);
                            i_reg  <= c_reg - CW'(1);
                            st_reg <= S_WALK;
                        end
                        else
                        begin
                            st_reg <= S_FINISH;
                        end
                    end
                end
                S_WALK:
                begin
                    if (i_reg == '0)
                    begin
                        cnt_reg[g_reg] <= c_reg + CW'(1);
                        st_reg         <= newlow_reg ? S_PMUL : S_FINISH;
                    end
                    else
                    begin
                        st_reg <= S_WCHK;
                    end
                end
                S_WCHK:
                begin
                    if (rd_val > v)
                    begin
                        i_reg  <= i_reg - CW'(1);
                        st_reg <= S_WALK;
                    end
                    else
                    begin
                        cnt_reg[g_reg] <= c_reg + CW'(1);
                        st_reg         <= newlow_reg ? S_PMUL : S_FINISH;
                    end
                end
                S_PMUL:
                begin
                    prod_reg <= mul_p;
                    st_reg   <= S_PRD;
                end
                S_PRD:
                begin
                    st_reg <= (cnt_reg[g_reg] == '0) ? S_FINISH : S_PCHK;
                end
                S_PCHK:
                begin
                    if (rd_lhs > prod_reg)
                    begin
                        if (emit_go)
                        begin
                            cnt_reg[g_reg] <= cnt_reg[g_reg] - CW'(1);
                            st_reg         <= S_PRD;
                        end
                    end
                    else
                    begin
                        st_reg <= S_FINISH;
                    end
                end
                S_REL:
                begin
                    if (rg_reg == GIW'(GROUPS))
                    begin
                        for (int g = 0; g < GROUPS; g++)
                        begin
                            used_reg[g] <= 1'b0;
                            cnt_reg[g]  <= '0;
                        end
                        st_reg <= S_FINISH;
                    end
                    else if (!used_reg[rg_idx] || i_reg == cnt_reg[rg_idx])
                    begin
                        rg_reg <= rg_reg + GIW'(1);
                        i_reg  <= '0;
                    end
                    else
                    begin
                        st_reg <= S_RCHK;
                    end
                end
                S_RCHK:
                begin
                    if (emit_go)
                    begin
                        i_reg  <= i_reg + CW'(1);
                        st_reg <= S_REL;
                    end
                end
                S_FINISH:
                begin
                    if (!pend_valid_reg || out_free)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CW'(ENTRIES))
        else $error("group list count above capacity");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left behind at item end");

    a_unused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !used_reg[0] |-> cnt_reg[0] == '0)
        else $error("free group slot holds entries");

endmodule

// ----- src/grouped_near_minimum_keep_filter.sv -----
// Grouped near-minimum keep filter. Offered items are kept per group in a list sorted by
// value (signed Q16.16, optionally divided by atom count); an item can be kept only when it
// sets a new group minimum or lies below minimum*(1-keep_fraction/65536), and every item or
// entry that is not kept produces one result (dropped, passed, or passed because the group
// table is full). A release emits every kept id in slot order, ascending value, and clears
// the store. A kept item produces no result; otherwise the final result of an input carries
// tlast. The front takes a new input only after handing the previous one on, and runs a
// per-atom division in a restoring divider, one quotient bit per cycle. A two-entry command
// queue feeds the back end, which takes the next command only after finishing the last and
// whose sorted insert goes through one single-port list memory. No clearing pass is needed
// after reset.
module grouped_near_minimum_keep_filter
    import gnmk_pkg::*;
#(
    parameter int GROUPS  = 4,
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // item_id[31:0], group_key[47:32], has_value[48],
                                   // property_value[80:49], atom_count[88:81], zero pad
    input  logic        s_tuser,   // func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_id
    output logic [1:0]  m_tuser,   // verdict
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data
);

    logic [15:0] keep_fraction_reg;
    logic        per_atom_reg;

    cmd_t        in_cmd;
    cmd_t        push_cmd;
    cmd_t        pop_cmd;
    logic        push_valid;
    logic        push_ready;
    logic        pop_valid;
    logic        pop_ready;

    // configuration writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_fraction_reg <= 16'd3277;
            per_atom_reg      <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_KEEP_FRACTION: keep_fraction_reg <= cfg_data;
                CFG_PER_ATOM:      per_atom_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // unpack the input transfer
    assign in_cmd = '{func: s_tuser, item_id: s_tdata[31:0], group_key: s_tdata[47:32],
                      has_value: s_tdata[48], value: s_tdata[80:49]};

    gnmk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .per_atom   (per_atom_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (in_cmd),
        .atom_count (s_tdata[88:81]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    gnmk_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    gnmk_back #(
        .GROUPS  (GROUPS),
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .keep_fraction (keep_fraction_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_cmd),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_id        (m_tdata),
        .out_verdict   (m_tuser),
        .out_last      (m_tlast)
    );

endmodule

// ----- sim/grouped_near_minimum_keep_filter_test.sv -----
`timescale 1ns / 1ps

module grouped_near_minimum_keep_filter_test;
    import gnmk_pkg::*;

    localparam int GROUPS     = 4;
    localparam int ENTRIES    = 16;
    localparam int IDLE_LIMIT = 20000;   // cycles without any transfer
    localparam int SETTLE     = 200;     // covers the longest offer in the back end

    // Scoreboard: tracks the group store and keeps the results still owed.
    class keep_store_board;
        typedef struct {
            logic [31:0] id;
            logic [1:0]  verdict;
            logic        last;
        } result_t;

        bit [15:0]   fraction;
        bit          per_atom;
        bit [15:0]   keys  [GROUPS];
        bit          used  [GROUPS];
        int          count [GROUPS];
        int          vals  [GROUPS][ENTRIES];
        bit [31:0]   ids   [GROUPS][ENTRIES];
        result_t     owed[$];
        int          errors;

        function new();
            fraction = 3277;
            per_atom = 1;
            errors   = 0;
            foreach (used[g])
            begin
                used[g]  = 0;
                count[g] = 0;
            end
        endfunction

        function void owe(logic [31:0] id, logic [1:0] verdict);
            result_t r;
            r.id      = id;
            r.verdict = verdict;
            r.last    = 1'b0;
            owed.push_back(r);
        endfunction

        // exact comparison of a*65536 against lowest*(65536-fraction)
        function int cmp_cutoff(int a, int lowest);
            longint lhs;
            longint rhs;
            lhs = longint'(a) * 65536;
            rhs = longint'(lowest) * longint'(65536 - int'(fraction));
            return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
        endfunction

        function void insert(int g, int pos, int v, logic [31:0] id);
            for (int i = count[g]; i > pos; i--)
            begin
                vals[g][i] = vals[g][i-1];
                ids[g][i]  = ids[g][i-1];
            end
            vals[g][pos] = v;
            ids[g][pos]  = id;
            count[g]++;
        endfunction

        function void offer(logic [31:0] id, logic [15:0] key, int v);
            int g;
            int free_slot;
            int pos;
            g = -1;
            free_slot = -1;
            for (int i = 0; i < GROUPS; i++)
            begin
                if (used[i] && keys[i] == key)
                begin
                    g = i;
                    break;
                end
                if (!used[i] && free_slot < 0)
                    free_slot = i;
            end
            if (g < 0)
            begin
                if (free_slot < 0)
                begin
                    owe(id, VERDICT_TABLE_FULL);
                    return;
                end
                g = free_slot;
                used[g]  = 1;
                keys[g]  = key;
                count[g] = 0;
            end
            if (count[g] == 0)
                insert(g, 0, v, id);
            else if (v < vals[g][0])
            begin
                // new minimum: evict the tail if full, then prune above the new cutoff
                if (count[g] >= ENTRIES)
                begin
                    owe(ids[g][count[g]-1], VERDICT_DROP);
                    count[g]--;
                end
                insert(g, 0, v, id);
                while (count[g] > 0 && cmp_cutoff(vals[g][count[g]-1], v) > 0)
                begin
                    owe(ids[g][count[g]-1], VERDICT_DROP);
                    count[g]--;
                end
            end
            else if (cmp_cutoff(v, vals[g][0]) < 0)
            begin
                if (count[g] >= ENTRIES)
                begin
                    if (v >= vals[g][count[g]-1])
                    begin
                        owe(id, VERDICT_DROP);
                        return;
                    end
                    owe(ids[g][count[g]-1], VERDICT_DROP);
                    count[g]--;
                end
                pos = count[g];
                while (pos > 0 && vals[g][pos-1] > v)
                    pos--;
                insert(g, pos, v, id);
            end
            else
                owe(id, VERDICT_DROP);
        endfunction

        // note one accepted input transfer and queue what it must produce
        function void note_input(logic func, logic [31:0] id, logic [15:0] key,
                                 logic has_value, logic [31:0] raw, logic [7:0] atoms);
            int start;
            int v;
            start = owed.size();
            if (func == FUNC_RELEASE)
            begin
                for (int g = 0; g < GROUPS; g++)
                begin
                    if (used[g])
                        for (int i = 0; i < count[g]; i++)
                            owe(ids[g][i], VERDICT_RELEASE);
                    used[g]  = 0;
                    count[g] = 0;
                end
            end
            else if (!has_value)
                owe(id, VERDICT_PASS);
            else
            begin
                v = $signed(raw);
                if (per_atom && atoms > 1)
                    v = v / int'(atoms);    // truncates toward zero
                offer(id, key, v);
            end
            if (owed.size() > start)
                owed[owed.size()-1].last = 1'b1;
        endfunction

        function void check_result(logic [31:0] id, logic [1:0] verdict, logic last);
            result_t r;
            if (owed.size() == 0)
            begin
                $error("unexpected result: out_id %h verdict %0d last %0b", id, verdict, last);
                errors++;
                return;
            end
            r = owed.pop_front();
            if (id !== r.id)
            begin
                $error("out_id: expected %h, got %h", r.id, id);
                errors++;
            end
            if (verdict !== r.verdict)
            begin
                $error("verdict: expected %0d, got %0d", r.verdict, verdict);
                errors++;
            end
            if (last !== r.last)
            begin
                $error("last: expected %0b, got %0b", r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_addr;
    logic [15:0] cfg_data;

    keep_store_board board = new();
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    logic [15:0] key_pool [6];

    always #4 clk = ~clk;

    grouped_near_minimum_keep_filter #(.GROUPS(GROUPS), .ENTRIES(ENTRIES)) dut (.*);

    // Result side: check every transfer, then pick the next ready level.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("** grouped_near_minimum_keep_filter: FAILED **");
            $finish;
        end
    end

    task automatic cfg_write(input logic addr, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (addr == CFG_KEEP_FRACTION)
            board.fraction = data;
        else
            board.per_atom = data[0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drive one input transfer; hold valid high across back-to-back items.
    task automatic send_item(input logic func, input logic [31:0] id, input logic [15:0] key,
                             input logic has_value, input logic [31:0] raw,
                             input logic [7:0] atoms);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, atoms, raw, has_value, key, id};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(func, id, key, has_value, raw, atoms);
    endtask

    task automatic offer_item(input logic [31:0] id, input logic [15:0] key,
                              input logic [31:0] raw);
        send_item(FUNC_OFFER, id, key, 1'b1, raw, 8'd1);
    endtask

    // Wait until every owed result is back, then let the back end settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_items(input int n);
        logic [31:0] raw;
        logic [7:0]  atoms;
        int          sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 3)
            begin
                send_item(FUNC_RELEASE, $urandom, 16'($urandom), 1'($urandom), $urandom,
                          8'($urandom));
                continue;
            end
            // half of the values lie near two bases, -100 and +100, so lists fill, prune and evict
            case ($urandom_range(3))
                0: raw = $urandom;
                1: raw = 32'hFF9C_0000 + $urandom_range(0, 32'h0006_0000);
                2: raw = 32'h0064_0000 - $urandom_range(0, 32'h0006_0000);
                default: raw = -$signed(32'($urandom_range(0, 32'h0200_0000)));
            endcase
            case ($urandom_range(3))
                0: atoms = 8'($urandom);
                1: atoms = 8'd0;
                default: atoms = 8'd1;
            endcase
            send_item(FUNC_OFFER, $urandom, key_pool[$urandom_range(5)],
                      (sel >= 8), raw, atoms);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_addr       = 1'b0;
        cfg_data       = '0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 6; i++)
            key_pool[i] = 16'($urandom);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 0: no idling, 5 percent window, raw values.
        cfg_write(CFG_KEEP_FRACTION, 16'd3277);
        cfg_write(CFG_PER_ATOM, 16'd0);
        send_item(FUNC_RELEASE, 32'h0, 16'h0, 1'b0, 32'h0, 8'h0);     // nothing kept
        send_item(FUNC_OFFER, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'h0, 8'hFF); // no value
        offer_item(32'h0000_0000, 16'h0000, -32'sd100 <<< 16);  // first of group
        offer_item(32'h0000_0001, 16'h0000, -32'sd97 <<< 16);   // below cutoff
        offer_item(32'h0000_0002, 16'h0000, -32'sd90 <<< 16);   // not below cutoff
        offer_item(32'h0000_0003, 16'h0000, -32'sd95 <<< 16);   // just below cutoff
        offer_item(32'h0000_0004, 16'h0000, -32'sd101 <<< 16);  // new minimum, prunes one
        offer_item(32'h0000_0005, 16'h0000, -32'sd200 <<< 16);  // new minimum, prunes all others
        offer_item(32'h0000_0006, 16'hFFFF, 32'sd10 <<< 16);
        offer_item(32'h0000_0007, 16'hFFFF, 32'sd5 <<< 16);     // prunes itself too
        offer_item(32'h0000_0008, 16'hFFFF, 32'sd7 <<< 16);     // group left empty
        offer_item(32'h0000_0009, 16'h0001, 32'h7FFF_FFFF);
        offer_item(32'h0000_000A, 16'h0002, 32'h8000_0000);
        offer_item(32'hFFFF_FFFF, 16'h0003, 32'h0);             // table full
        offer_item(32'h0000_000B, 16'h0002, 32'h8000_0000);     // tie at minimum
        send_item(FUNC_OFFER, 32'h0000_000C, 16'h0001, 1'b1, 32'h0, 8'h0); // atom count 0
        send_item(FUNC_RELEASE, 32'h0, 16'h0, 1'b0, 32'h0, 8'h0);
        // fill one list past its depth to force evictions
        for (int i = 0; i < ENTRIES + 3; i++)
            offer_item(32'h100 + i, 16'h0000, -32'sd1000 + 32'(i % 7));
        random_items(80);
        drain();

        // Phase 1: sender idles, widest window, per-atom division.
        send_idle_pct = 83;
        cfg_write(CFG_KEEP_FRACTION, 16'hFFFF);
        cfg_write(CFG_PER_ATOM, 16'd1);
        random_items(100);
        drain();

        // Phase 2: receiver stalls, zero window.
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        cfg_write(CFG_KEEP_FRACTION, 16'd0);
        random_items(100);
        drain();

        // Phase 3: both idle, random settings.
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        cfg_write(CFG_KEEP_FRACTION, 16'($urandom));
        cfg_write(CFG_PER_ATOM, 16'($urandom));
        random_items(100);
        send_item(FUNC_RELEASE, 32'h0, 16'h0, 1'b0, 32'h0, 8'h0);
        drain();

        if (board.errors == 0)
            $display("** grouped_near_minimum_keep_filter: PASSED **");
        else
            $display("** grouped_near_minimum_keep_filter: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/gnmk_pkg.sv
src/gnmk_front.sv
src/gnmk_fifo.sv
src/gnmk_back.sv
src/grouped_near_minimum_keep_filter.sv
sim/grouped_near_minimum_keep_filter_test.sv
